### src/fsd2_pkg.sv
// shared types and constants for the sd2 frame deframer
package fsd2_pkg;

   // largest payload accepted in one frame
   localparam int MAX_DATA = 246;

   // delimiters and length bounds
   localparam logic [7:0] START_DELIM = 8'h68;
   localparam logic [7:0] END_DELIM   = 8'h16;
   localparam logic [7:0] HDR_LEN     = 8'd3;
   localparam logic [7:0] MAX_LEN     = 8'(MAX_DATA + 3);

   // result kinds
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // frame status codes
   typedef enum logic [1:0] {
      STAT_GOOD    = 2'd0,
      STAT_BAD_SUM = 2'd1,
      STAT_BAD_ED  = 2'd2
   } status_type;

   // parser phases
   typedef enum logic [3:0] {
      PH_HUNT = 4'd0,
      PH_LEN  = 4'd1,
      PH_LEN2 = 4'd2,
      PH_SD   = 4'd3,
      PH_DA   = 4'd4,
      PH_SA   = 4'd5,
      PH_FC   = 4'd6,
      PH_DATA = 4'd7,
      PH_FCS  = 4'd8,
      PH_ED   = 4'd9
   } phase_type;

   // one result item
   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [7:0] dest_addr;
      logic [7:0] src_addr;
      logic [7:0] func_code;
      logic [7:0] data_count;
      logic [1:0] frame_status;
   } rsp_item_type;

endpackage

### src/fsd2_parser.sv
// per-byte frame parser: phase tracking, header capture and sum check
module fsd2_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_valid,
   input  logic [7:0]           rx_byte,
   output logic                 item_valid,
   output fsd2_pkg::rsp_item_type item
);
   import fsd2_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] dest_ff, dest_in;
   logic [7:0] src_ff, src_in;
   logic [7:0] func_ff, func_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] left_ff, left_in;
   logic       fail_ff, fail_in;
   logic [7:0] sum_add;
   logic [7:0] left_dec;
   logic [7:0] count;

   assign sum_add  = sum_ff + rx_byte;
   assign left_dec = left_ff - 8'd1;
   assign count    = length_ff - HDR_LEN;

   // next state and result for one byte
   always_comb begin
      phase_in   = phase_ff;
      length_in  = length_ff;
      dest_in    = dest_ff;
      src_in     = src_ff;
      func_in    = func_ff;
      sum_in     = sum_ff;
      left_in    = left_ff;
      fail_in    = fail_ff;
      item_valid = 1'b0;
      item       = '0;
      unique case (phase_ff)
         PH_LEN: begin
            length_in = rx_byte;
            phase_in  = PH_LEN2;
         end
         PH_LEN2: begin
            if (rx_byte != length_ff || length_ff < HDR_LEN || length_ff > MAX_LEN) begin
               phase_in = PH_HUNT;
            end else begin
               phase_in = PH_SD;
            end
         end
         PH_SD: begin
            phase_in = (rx_byte == START_DELIM) ? PH_DA : PH_HUNT;
         end
         PH_DA: begin
            dest_in  = rx_byte;
            sum_in   = rx_byte;
            phase_in = PH_SA;
         end
         PH_SA: begin
            src_in   = rx_byte;
            sum_in   = sum_add;
            phase_in = PH_FC;
         end
         PH_FC: begin
            func_in  = rx_byte;
            sum_in   = sum_add;
            left_in  = count;
            phase_in = (count == 8'd0) ? PH_FCS : PH_DATA;
         end
         PH_DATA: begin
            item_valid     = 1'b1;
            item.kind      = KIND_DATA;
            item.data_byte = rx_byte;
            sum_in         = sum_add;
            left_in        = left_dec;
            if (left_dec == 8'd0) begin
               phase_in = PH_FCS;
            end
         end
         PH_FCS: begin
            fail_in  = (rx_byte != sum_ff);
            phase_in = PH_ED;
         end
         PH_ED: begin
            item_valid      = 1'b1;
            item.kind       = KIND_REPORT;
            item.dest_addr  = dest_ff;
            item.src_addr   = src_ff;
            item.func_code  = func_ff;
            item.data_count = count;
            if (rx_byte != END_DELIM) begin
               item.frame_status = STAT_BAD_ED;
            end else begin
               item.frame_status = fail_ff ? STAT_BAD_SUM : STAT_GOOD;
            end
            phase_in = PH_HUNT;
         end
         default: begin
            // hunting, and any phase code without a meaning
            phase_in = (rx_byte == START_DELIM) ? PH_LEN : PH_HUNT;
         end
      endcase
   end

   // phase register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else if (byte_valid) begin
         phase_ff <= phase_in;
      end
   end

   // frame context registers
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         dest_ff   <= '0;
         src_ff    <= '0;
         func_ff   <= '0;
         sum_ff    <= '0;
         left_ff   <= '0;
         fail_ff   <= 1'b0;
      end else if (byte_valid) begin
         length_ff <= length_in;
         dest_ff   <= dest_in;
         src_ff    <= src_in;
         func_ff   <= func_in;
         sum_ff    <= sum_in;
         left_ff   <= left_in;
         fail_ff   <= fail_in;
      end
   end

endmodule

### src/fsd2_out_buf.sv
// result register with a skid stage behind it
module fsd2_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  fsd2_pkg::rsp_item_type in_item,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output fsd2_pkg::rsp_item_type out_item
);
   import fsd2_pkg::*;

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_item_type out_item_ff, out_item_in;
   rsp_item_type skid_item_ff, skid_item_in;
   logic         out_free;

   assign out_free  = !out_valid_ff || out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

   // refill the output register from the skid stage first
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_item_in   = out_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_item_in   = skid_item_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_item_in  = in_item;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_item_in  = in_item;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      out_item_ff  <= out_item_in;
      skid_item_ff <= skid_item_in;
   end

endmodule

### src/fieldbus_sd2_frame_deframer_top.sv
// Variable-length (SD2) fieldbus frame deframer.
// Request channel (req_): one received byte per request in req_tdata.
// Result channel (rsp_): rsp_tuser says what the item is. A payload item
// (rsp_tuser = 0) carries one data byte of the current frame; a report item
// (rsp_tuser = 1) closes the frame with destination, source, function code,
// payload count and status (good, bad sum check, bad end delimiter).
// Frames with a length mismatch, a missing second start delimiter or a
// length outside 3 .. MAX_DATA+3 are dropped silently and the search for a
// start delimiter resumes at the next byte.
// Throughput: one request per cycle while req_tready is high; the phase
// register and sum check update from the incoming byte in a single step.
// Output: a result is registered in the result register, whose outputs drive
// rsp_; while the receiver stalls it first waits in the skid stage.
// Stall: a skid stage holds one result while the receiver stalls, so
// req_tready only drops once both the result register and the skid stage
// are full.
// Reset: synchronous, clears the parser to hunting and empties both
// result stages.
module fieldbus_sd2_frame_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] data_byte, [15:8] dest_addr, [23:16] src_addr,
                                    // [31:24] func_code, [39:32] data_count,
                                    // [41:40] frame_status, [47:42] zero
   output logic [0:0]  rsp_tuser    // [0] kind
);
   import fsd2_pkg::*;

   logic         req_take;
   logic         item_valid;
   rsp_item_type item;
   rsp_item_type rsp_item;

   assign req_take = req_tvalid && req_tready;

   // byte parser
   fsd2_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_take),
      .rx_byte    (req_tdata),
      .item_valid (item_valid),
      .item       (item)
   );

   // result register and skid stage
   fsd2_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_take && item_valid),
      .in_item   (item),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   // pack the result
   assign rsp_tuser = rsp_item.kind;
   assign rsp_tdata = {6'd0, rsp_item.frame_status, rsp_item.data_count,
                       rsp_item.func_code, rsp_item.src_addr, rsp_item.dest_addr,
                       rsp_item.data_byte};

`ifndef SYNTHESIS
   // payload items carry nothing but the data byte
   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == KIND_DATA |-> rsp_tdata[47:8] == 40'd0)
      else $error("payload item with nonzero report fields");

   // report items carry a defined status and no data byte
   a_report_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] == KIND_REPORT |->
         rsp_tdata[41:40] != 2'd3 && rsp_tdata[7:0] == 8'd0)
      else $error("report item with bad status or data byte");

   // back pressure only while a result is waiting
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request side stalled with no result pending");
`endif

endmodule
